@@ design/lpsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsp_pkg
// Shared constants and types for the lidar packet stack parser.
// ----------------------------------------------------------------------------
package lpsp_pkg;

    // Packet length limit and byte position counter width
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES - 1);

    // Compare width wide enough for byte position and 8-bit register values
    localparam int CMP_W = ((POS_W > 8) ? POS_W : 8) + 1;

    // Fixed framing sizes
    localparam int PREAMBLE_BYTES  = 20;
    localparam int HEADER_BYTES    = 60;
    localparam int POINT_BYTES     = 4;

    // Point word masks
    localparam logic [15:0] DIST_MASK   = 16'h1FFF;
    localparam logic [2:0]  STATUS_MASK = 3'h7;

    // Configuration port
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKETS_PER_STACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_OFFSET       = 2'd2;

    localparam logic [3:0] PACKETS_RESET = 4'd3;
    localparam logic [7:0] HEADER_RESET  = 8'(PREAMBLE_BYTES + HEADER_BYTES);
    localparam logic [7:0] SCAN_RESET    = 8'd40;

    // Result kinds
    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [3:0] packets_per_stack;
        logic [7:0] header_length;
        logic [7:0] scan_offset;
    } t_cfg;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
        logic       good;
        logic       stack_done;
        logic       header_short;
        logic       is_data;
        logic       scan_clear;
        logic       scan_we;
        logic [1:0] scan_lane;
    } t_item;

endpackage
`default_nettype wire

@@ design/lpsp_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsp_in_if
// Byte stream channel: one packet byte and its last-of-packet flag per beat.
// ----------------------------------------------------------------------------
interface lpsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_of_packet;

    modport source (output valid, output byte_value, output last_of_packet, input ready);
    modport sink   (input valid, input byte_value, input last_of_packet, output ready);
endinterface
`default_nettype wire

@@ design/lpsp_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsp_out_if
// Result channel: one decoded point or one packet verdict per beat.
// ----------------------------------------------------------------------------
interface lpsp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [12:0] distance;
    logic [2:0]  status_bits;
    logic [15:0] intensity;
    logic [15:0] point_number;
    logic [31:0] scan_number;
    logic        packet_good;
    logic        stack_done;
    logic [1:0]  leftover_bytes;
    logic        header_short;

    modport source (
        output valid, input ready,
        output kind, output distance, output status_bits, output intensity,
        output point_number, output scan_number, output packet_good,
        output stack_done, output leftover_bytes, output header_short
    );
    modport sink (
        input valid, output ready,
        input kind, input distance, input status_bits, input intensity,
        input point_number, input scan_number, input packet_good,
        input stack_done, input leftover_bytes, input header_short
    );
endinterface
`default_nettype wire

@@ design/lidar_packet_stack_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_packet_stack_parser
// Checks packet checksums, captures the stack scan number and decodes points.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one packet byte per beat; last_of_packet marks the checksum
//   byte. o_out carries one result per beat: a decoded point (kind 0) after
//   every fourth data byte, and a verdict (kind 1) after every checksum byte.
//   Points of a packet whose verdict is bad are to be discarded downstream.
//   The configuration port writes packets_per_stack (index 0), header_length
//   (index 1) and scan_offset (index 2) on any edge with i_cfg_we high; write
//   only while the block is idle.
// Timing:
//   A byte accepted from i_in is written into the queue, from which the back
//   end pops it into the output register. One byte is taken every cycle while
//   i_in.ready is high; checksums are in the front end, packing in the back end.
// Reset:
//   Synchronous, active low. Configuration returns to 3 / 80 / 40, the queue
//   empties and all parser state clears. No clearing pass is needed.
// Stall:
//   While o_out.ready is low the result register holds and the two-entry
//   queue fills; i_in.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module lidar_packet_stack_parser
    import lpsp_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    lpsp_in_if.sink                i_in,
    lpsp_out_if.source             o_out
);

    t_cfg  r_cfg;
    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.packets_per_stack <= PACKETS_RESET;
            r_cfg.header_length     <= HEADER_RESET;
            r_cfg.scan_offset       <= SCAN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PACKETS_PER_STACK: r_cfg.packets_per_stack <= i_cfg_data[3:0];
                CFG_HEADER_LENGTH:     r_cfg.header_length     <= i_cfg_data[7:0];
                CFG_SCAN_OFFSET:       r_cfg.scan_offset       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    lpsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    lpsp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    lpsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

@@ design/lpsp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsp_front
// Accepts packet bytes, tracks checksum, byte position and packet index,
// and classifies each byte as header, scan, data or checksum.
// ----------------------------------------------------------------------------
module lpsp_front
    import lpsp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cfg        i_cfg,
    lpsp_in_if.sink     i_in,
    output logic        o_push_valid,
    output t_item       o_push_item,
    input  wire         i_push_ready
);

    logic [7:0]       r_xor,  n_xor;
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [3:0]       r_pidx, n_pidx;

    logic             accept;
    logic             first;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] hdr_ext;
    logic [CMP_W-1:0] off_ext;
    logic [CMP_W-1:0] scan_diff;
    logic             in_header;
    logic             good;
    logic [3:0]       pidx_inc;
    logic             done;

    // Handshake passes straight through to the queue
    assign accept       = i_in.valid && i_in.ready;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    // Classify the byte against position and stack state
    always_comb begin
        first     = (r_pidx == 4'd0);
        pos_ext   = CMP_W'(r_pos);
        hdr_ext   = CMP_W'(i_cfg.header_length);
        off_ext   = CMP_W'(i_cfg.scan_offset);
        scan_diff = pos_ext - off_ext;
        in_header = first && (pos_ext < hdr_ext);
        good      = (r_xor == i_in.byte_value);
        pidx_inc  = r_pidx + 4'd1;
        done      = good && (pidx_inc >= i_cfg.packets_per_stack);

        o_push_item.byte_value   = i_in.byte_value;
        o_push_item.is_last      = i_in.last_of_packet;
        o_push_item.good         = good;
        o_push_item.stack_done   = done;
        o_push_item.header_short = in_header;
        o_push_item.is_data      = !i_in.last_of_packet && !in_header;
        o_push_item.scan_clear   = !i_in.last_of_packet && first && (r_pos == '0);
        o_push_item.scan_we      = !i_in.last_of_packet && first && (pos_ext >= off_ext)
                                   && (scan_diff < CMP_W'(POINT_BYTES));
        o_push_item.scan_lane    = scan_diff[1:0];
    end

    // Advance checksum, position and packet index
    always_comb begin
        n_xor  = r_xor;
        n_pos  = r_pos;
        n_pidx = r_pidx;
        if (accept) begin
            if (i_in.last_of_packet) begin
                n_xor = 8'd0;
                n_pos = '0;
                if (good) begin
                    n_pidx = done ? 4'd0 : pidx_inc;
                end
            end else begin
                n_xor = r_xor ^ i_in.byte_value;
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor  <= 8'd0;
            r_pos  <= '0;
            r_pidx <= 4'd0;
        end else begin
            r_xor  <= n_xor;
            r_pos  <= n_pos;
            r_pidx <= n_pidx;
        end
    end

endmodule
`default_nettype wire

@@ design/lpsp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsp_queue
// Short register queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module lpsp_queue
    import lpsp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push_valid,
    input  t_item       i_push_item,
    output logic        o_push_ready,
    output logic        o_pop_valid,
    output t_item       o_pop_item,
    input  wire         i_pop_ready
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

@@ design/lpsp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsp_back
// Captures the scan number, packs data bytes into points, restores the
// assembler on failed packets and drives the registered result channel.
// ----------------------------------------------------------------------------
module lpsp_back
    import lpsp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_pop_valid,
    input  t_item       i_pop_item,
    output logic        o_pop_ready,
    lpsp_out_if.source  o_out
);

    // Assembler and stack state
    logic [23:0] r_asm,         n_asm;
    logic [1:0]  r_fill,        n_fill;
    logic [15:0] r_count,       n_count;
    logic [23:0] r_saved_asm,   n_saved_asm;
    logic [1:0]  r_saved_fill,  n_saved_fill;
    logic [15:0] r_saved_count, n_saved_count;
    logic [31:0] r_scan,        n_scan;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic        r_kind,      n_kind;
    logic [12:0] r_dist,      n_dist;
    logic [2:0]  r_status,    n_status;
    logic [15:0] r_inten,     n_inten;
    logic [15:0] r_pnum,      n_pnum;
    logic [31:0] r_oscan,     n_oscan;
    logic        r_good,      n_good;
    logic        r_done,      n_done;
    logic [1:0]  r_left,      n_left;
    logic        r_short,     n_short;

    logic        pop;
    logic [15:0] w0;

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign w0          = r_asm[15:0];

    // Execute one classified beat
    always_comb begin
        n_asm         = r_asm;
        n_fill        = r_fill;
        n_count       = r_count;
        n_saved_asm   = r_saved_asm;
        n_saved_fill  = r_saved_fill;
        n_saved_count = r_saved_count;
        n_scan        = r_scan;

        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_dist      = r_dist;
        n_status    = r_status;
        n_inten     = r_inten;
        n_pnum      = r_pnum;
        n_oscan     = r_oscan;
        n_good      = r_good;
        n_done      = r_done;
        n_left      = r_left;
        n_short     = r_short;

        if (pop) begin
            if (i_pop_item.is_last) begin
                // Packet verdict
                n_out_valid = 1'b1;
                n_kind      = KIND_VERDICT;
                n_dist      = 13'd0;
                n_status    = 3'd0;
                n_inten     = 16'd0;
                n_oscan     = r_scan;
                n_good      = i_pop_item.good;
                n_done      = 1'b0;
                n_left      = 2'd0;
                n_short     = i_pop_item.header_short;
                if (i_pop_item.good) begin
                    n_pnum = r_count;
                    if (i_pop_item.stack_done) begin
                        n_done  = 1'b1;
                        n_left  = r_fill;
                        n_asm   = 24'd0;
                        n_fill  = 2'd0;
                        n_count = 16'd0;
                    end
                    n_saved_asm   = n_asm;
                    n_saved_fill  = n_fill;
                    n_saved_count = n_count;
                end else begin
                    n_asm   = r_saved_asm;
                    n_fill  = r_saved_fill;
                    n_count = r_saved_count;
                    n_pnum  = r_saved_count;
                end
            end else begin
                // Scan number capture in the first packet
                if (i_pop_item.scan_clear) begin
                    n_scan = 32'd0;
                end
                if (i_pop_item.scan_we) begin
                    n_scan = n_scan
                             | (32'(i_pop_item.byte_value) << {i_pop_item.scan_lane, 3'b000});
                end
                // Point packing
                if (i_pop_item.is_data) begin
                    if (r_fill != 2'd3) begin
                        n_asm  = r_asm | (24'(i_pop_item.byte_value) << {r_fill, 3'b000});
                        n_fill = r_fill + 2'd1;
                    end else begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_POINT;
                        n_dist      = 13'(w0 & DIST_MASK);
                        n_status    = 3'(w0 >> 13) & STATUS_MASK;
                        n_inten     = {i_pop_item.byte_value, r_asm[23:16]};
                        n_pnum      = r_count;
                        n_oscan     = n_scan;
                        n_good      = 1'b0;
                        n_done      = 1'b0;
                        n_left      = 2'd0;
                        n_short     = 1'b0;
                        n_asm       = 24'd0;
                        n_fill      = 2'd0;
                        if (r_count != 16'hFFFF) begin
                            n_count = r_count + 16'd1;
                        end
                    end
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm         <= 24'd0;
            r_fill        <= 2'd0;
            r_count       <= 16'd0;
            r_saved_asm   <= 24'd0;
            r_saved_fill  <= 2'd0;
            r_saved_count <= 16'd0;
            r_scan        <= 32'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_asm         <= n_asm;
            r_fill        <= n_fill;
            r_count       <= n_count;
            r_saved_asm   <= n_saved_asm;
            r_saved_fill  <= n_saved_fill;
            r_saved_count <= n_saved_count;
            r_scan        <= n_scan;
            r_out_valid   <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_dist   <= n_dist;
        r_status <= n_status;
        r_inten  <= n_inten;
        r_pnum   <= n_pnum;
        r_oscan  <= n_oscan;
        r_good   <= n_good;
        r_done   <= n_done;
        r_left   <= n_left;
        r_short  <= n_short;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.distance       = r_dist;
    assign o_out.status_bits    = r_status;
    assign o_out.intensity      = r_inten;
    assign o_out.point_number   = r_pnum;
    assign o_out.scan_number    = r_oscan;
    assign o_out.packet_good    = r_good;
    assign o_out.stack_done     = r_done;
    assign o_out.leftover_bytes = r_left;
    assign o_out.header_short   = r_short;

`ifndef NO_ASSERTIONS
    // A completed stack clears the assembler and point counter
    a_stack_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_pop_item.is_last && i_pop_item.good && i_pop_item.stack_done
        |=> (r_count == 16'd0) && (r_fill == 2'd0))
        else $error("stack end did not clear assembler");

    // A failed packet restores the saved assembler state
    a_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_pop_item.is_last && !i_pop_item.good
        |=> (r_count == r_saved_count) && (r_fill == r_saved_fill) && (r_asm == r_saved_asm))
        else $error("failed packet did not restore assembler");

    // The fourth data byte emits a point and empties the assembler
    a_point_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_pop_item.is_last && i_pop_item.is_data && (r_fill == 2'd3)
        |=> r_out_valid && (r_kind == KIND_POINT) && (r_fill == 2'd0))
        else $error("completed point not emitted");
`endif

endmodule
`default_nettype wire
